[src/double_hash_table_unit_defines.svh]
// Assertion macros for the double hashing table unit
`ifndef DOUBLE_HASH_TABLE_UNIT_DEFINES_SVH
`define DOUBLE_HASH_TABLE_UNIT_DEFINES_SVH

// Clocked check, masked while reset is high
`define DHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define DHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dht_pkg.sv]
// Shared constants and types for the double hashing table unit
package dht_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int SIZE_W        = 7;   // configured size and probe index
  localparam int CNT_W         = 7;   // occupied count
  localparam int KEY_W         = 32;
  localparam int VAL_W         = 32;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 3;
  localparam int SLOT_W        = 6;
  localparam int SIZE_RESET    = 64;

  // request codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_GONE  = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

[src/double_hash_table_unit.sv]
// Double hashing open-addressed table: top level
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_type, key, record_value
//  res      out        res_valid/res_stall   status, slot_index, found_value, removed_count
//  cfg      in         cfg_valid/cfg_ready   table_size
//
// A request is taken, then passes through the shared bit-serial divider (hash, then
// step) and through probes of the slot memory, each a registered read and then a check
// (up to size+1 probes); the result is then loaded into the result register.
// Requests answered without probing (full, empty, unused code) skip the divider.
// After reset a clearing pass over all TABLE_DEPTH slots marks every slot empty;
// requests are stalled meanwhile, configuration writes are taken.
// A stalled result is held; the next request is taken while it waits.
module double_hash_table_unit #(
  parameter int TABLE_DEPTH = dht_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [dht_pkg::OP_W-1:0]      req_type,
  input  logic [dht_pkg::KEY_W-1:0]     key,
  input  logic signed [dht_pkg::VAL_W-1:0] record_value,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [dht_pkg::STATUS_W-1:0]  status,
  output logic [dht_pkg::SLOT_W-1:0]    slot_index,
  output logic signed [dht_pkg::VAL_W-1:0] found_value,
  output logic [dht_pkg::CNT_W-1:0]     removed_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dht_pkg::SIZE_W-1:0]    table_size
);
  import dht_pkg::*;
  `include "double_hash_table_unit_defines.svh"

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_PRB_RD, S_PRB_CHK, S_FIN
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   size_reg;
  logic [SIZE_W-1:0]   s;
  logic [SIZE_W-1:0]   s_eff;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;
  logic [CNT_W-1:0]    occupied;
  logic [IW-1:0]       clr_idx;
  logic [KEY_W-1:0]    dvd;
  logic [SIZE_W-1:0]   rem;
  logic [4:0]          div_cnt;
  logic [SIZE_W-1:0]   idx;
  logic [SIZE_W-1:0]   step;
  logic [SIZE_W:0]     n;
  logic [CNT_W-1:0]    removed;
  logic [STATUS_W-1:0] st_q;
  logic [SIZE_W-1:0]   slot_q;
  logic [VAL_W-1:0]    fval_q;

  entry_t              mem [TABLE_DEPTH];
  entry_t              rd_q;
  logic                we;
  logic [IW-1:0]       waddr;
  entry_t              wdata;

  logic [SIZE_W:0]     rem_sh;
  logic                ge;
  logic [SIZE_W-1:0]   rem_new;
  logic [SIZE_W:0]     sum;
  logic [SIZE_W-1:0]   idx_adv;
  logic                last;
  logic                hit;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);

  // effective size: zero acts as one, clamp to the depth
  always_comb begin
    s_eff = size_reg;
    if (size_reg == '0) s_eff = SIZE_W'(1);
    else if (int'(size_reg) > TABLE_DEPTH) s_eff = SIZE_W'(TABLE_DEPTH);
  end

  // restoring divider step, one quotient bit a cycle
  assign rem_sh  = {rem, dvd[KEY_W-1]};
  assign ge      = (rem_sh >= {1'b0, s});
  assign rem_new = ge ? SIZE_W'(rem_sh - {1'b0, s}) : rem_sh[SIZE_W-1:0];

  // next probe slot and probe checks
  assign sum     = {1'b0, idx} + {1'b0, step};
  assign idx_adv = (sum >= {1'b0, s}) ? SIZE_W'(sum - {1'b0, s}) : sum[SIZE_W-1:0];
  assign last    = (n == {1'b0, s});
  assign hit     = (rd_q.mark == MARK_USED) && (rd_q.key == key_q);

  // memory write selection
  always_comb begin
    we    = 1'b0;
    waddr = IW'(idx);
    wdata = '{mark: MARK_GONE, key: '0, value: '0};
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '{mark: MARK_EMPTY, key: '0, value: '0};
    end else if (state == S_PRB_CHK) begin
      if (op == OP_INSERT && rd_q.mark != MARK_USED) begin
        we    = 1'b1;
        wdata = '{mark: MARK_USED, key: key_q, value: val_q};
      end else if (op == OP_DELETE && hit) begin
        we = 1'b1;
      end
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[IW'(idx)];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_W'(SIZE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= table_size;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      occupied  <= '0;
      res_valid <= 1'b0;
    end else begin
      // the finish state decides res_valid itself
      if (res_valid && !res_stall && state != S_FIN) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == IW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            op      <= req_type;
            key_q   <= key;
            val_q   <= record_value;
            s       <= s_eff;
            dvd     <= key;
            rem     <= '0;
            div_cnt <= '0;
            removed <= '0;
            slot_q  <= '0;
            fval_q  <= '0;
            st_q    <= ST_NOT_FOUND;
            if (req_type != OP_INSERT && req_type != OP_DELETE &&
                req_type != OP_SEARCH) begin
              state <= S_FIN;
            end else if (req_type == OP_INSERT && occupied >= s_eff) begin
              st_q  <= ST_FULL;
              state <= S_FIN;
            end else if (req_type != OP_INSERT && occupied == '0) begin
              st_q  <= ST_EMPTY;
              state <= S_FIN;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          dvd     <= {dvd[KEY_W-2:0], ge};
          rem     <= rem_new;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            idx   <= rem_new;
            rem   <= '0;
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          dvd     <= {dvd[KEY_W-2:0], ge};
          rem     <= rem_new;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            step  <= (rem_new == '0) ? SIZE_W'(1) : rem_new;
            n     <= '0;
            state <= S_PRB_RD;
          end
        end
        S_PRB_RD: begin
          state <= S_PRB_CHK;
        end
        S_PRB_CHK: begin
          idx   <= idx_adv;
          n     <= n + 1'b1;
          state <= last ? S_FIN : S_PRB_RD;
          priority if (op == OP_INSERT) begin
            if (rd_q.mark != MARK_USED) begin
              occupied <= occupied + CNT_W'(1);
              st_q     <= ST_INSERTED;
              slot_q   <= idx;
              state    <= S_FIN;
            end else if (last) begin
              st_q <= ST_FULL;
            end
          end else if (rd_q.mark == MARK_EMPTY) begin
            state <= S_FIN;
          end else if (op == OP_DELETE) begin
            if (hit) begin
              if (occupied != '0) occupied <= occupied - CNT_W'(1);
              removed <= removed + CNT_W'(1);
              st_q    <= ST_DELETED;
            end
          end else if (hit) begin
            st_q   <= ST_FOUND;
            slot_q <= idx;
            fval_q <= rd_q.value;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (!res_valid || !res_stall) begin
            res_valid     <= 1'b1;
            status        <= st_q;
            slot_index    <= slot_q[SLOT_W-1:0];
            found_value   <= fval_q;
            removed_count <= removed;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `DHT_ASSERT(a_res_from_fin, $rose(res_valid) |-> $past(state == S_FIN), "result without finish")
  `DHT_ASSERT(a_insert_counts, (state == S_PRB_CHK && we && op == OP_INSERT) |=> (occupied == $past(occupied) + CNT_W'(1)), "insert did not count")
  `DHT_ASSERT_ALWAYS(a_clear_stalls, (state == S_CLEAR) |-> req_stall, "request taken during clear")

endmodule
